### design/egop_pkg.sv
// Shared constants, types and knot tables for the exposure/gamma/offset pixel block
`default_nettype none
package egop_pkg;

  localparam int LOG_SEG = 64;
  localparam int EXP_SEG = 64;
  localparam int LOG_BITS = $clog2(LOG_SEG);
  localparam int EXP_BITS = $clog2(EXP_SEG);

  // pipeline depth, stage 1 is the normalize stage, the last one is the output register
  localparam int NSTG = 10;

  localparam int CODE_W = 16;
  localparam int NORM_W = 25;
  localparam int TERM_W = 28;
  localparam int SUM_W  = 28;
  localparam int LG_W   = 22;
  localparam int Z_W    = 32;
  localparam int Y_W    = 33;
  localparam int Q_W    = 58;
  localparam int KNOT_W = 18;
  localparam int CFG_W  = 25;

  localparam logic [31:0] RECIP_255 = 32'h8080_8081;

  typedef enum logic [2:0] {
    REG_DEPTH  = 3'd0,
    REG_OFFSET = 3'd1,
    REG_GAMMA  = 3'd2,
    REG_INVG   = 3'd3,
    REG_GAIN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              depth16;
    logic              gamma_en;
    logic [24:0]       inv_gamma;
    logic [24:0]       gain;
  } lane_cfg_t;

  typedef logic [LOG_SEG:0][KNOT_W-1:0] log_tab_t;
  typedef logic [EXP_SEG:0][KNOT_W-1:0] exp_tab_t;

  function automatic longint unsigned isqrt64(longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bitv;
    v = v_in;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t tab;
    longint unsigned y;
    longint unsigned acc;
    for (int k = 0; k < LOG_SEG; k++) begin
      y = ((64'(LOG_SEG) + 64'(k)) << 30) / LOG_SEG;
      acc = 0;
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 30;
        acc = acc << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          acc = acc | 64'd1;
        end
      end
      tab[k] = KNOT_W'((acc + 64'd128) >> 8);
    end
    tab[LOG_SEG] = KNOT_W'(65536);
    return tab;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    longint unsigned roots [0:30];
    longint unsigned f;
    longint unsigned p;
    roots[0] = 64'd2 << 30;
    for (int i = 1; i <= 30; i++) roots[i] = isqrt64(roots[i-1] << 30);
    for (int k = 0; k < EXP_SEG; k++) begin
      f = (64'(k) << 30) / EXP_SEG;
      p = 64'd1 << 30;
      for (int i = 1; i <= 30; i++) begin
        if (((f >> (30 - i)) & 64'd1) != 0) p = (p * roots[i] + (64'd1 << 29)) >> 30;
      end
      tab[k] = KNOT_W'((p + (64'd1 << 13)) >> 14);
    end
    tab[EXP_SEG] = KNOT_W'(131072);
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam exp_tab_t EXP_TAB = build_exp();

endpackage
`default_nettype wire

### design/egop_norm.sv
// Channel code normalize stage: code / max in Q16 with rounding
`default_nettype none
module egop_norm (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic                          depth16,
  input  wire logic [egop_pkg::CODE_W-1:0]   code,
  output logic      [egop_pkg::NORM_W-1:0]   norm_r
);

  logic [31:0] num;
  logic [63:0] prod;
  logic [egop_pkg::NORM_W-1:0] norm_nxt;

  // divide by 255 through the reciprocal, the +127 is half of max
  assign num  = {code, 16'h007F};
  assign prod = 64'(num) * 64'(egop_pkg::RECIP_255);

  always_comb begin
    if (depth16) norm_nxt = {8'd0, code, 1'b0};
    else         norm_nxt = prod[63:39];
  end

  always_ff @(posedge clk) begin
    if (en) norm_r <= norm_nxt;
  end

endmodule
`default_nettype wire

### design/egop_lane.sv
// One color lane: offset, clamp, log2/exp2 power, gain and rescale
`default_nettype none
module egop_lane (
  input  wire logic                               clk,
  input  wire logic [egop_pkg::NSTG-1:0]          en,
  input  wire egop_pkg::lane_cfg_t                cfg,
  input  wire logic [egop_pkg::NORM_W-1:0]        norm,
  input  wire logic signed [egop_pkg::TERM_W-1:0] term,
  output logic      [egop_pkg::CODE_W-1:0]        code_r
);

  localparam int LPOS_W = 16 + egop_pkg::LOG_BITS + 1;
  localparam int EPOS_W = 16 + egop_pkg::EXP_BITS + 1;

  logic [egop_pkg::NORM_W-1:0] v2_r;

  // clamp stage
  logic signed [egop_pkg::SUM_W:0] sum;
  logic [egop_pkg::SUM_W-1:0]      s3_r, s3_nxt;

  // leading-one stage
  logic [4:0]                 e_lz;
  logic [egop_pkg::SUM_W-1:0] nrm;
  logic [4:0]                 e4_r;
  logic [15:0]                t4_r;
  logic [egop_pkg::SUM_W-1:0] s4_r;
  logic                       z4_r;

  // log interpolation
  logic [LPOS_W-1:0]               lpos;
  logic [egop_pkg::LOG_BITS-1:0]   lseg;
  logic [egop_pkg::LOG_BITS:0]     lseg1;
  logic [egop_pkg::KNOT_W-1:0]     lk0, lk1, ldiff;
  logic [33:0]                     lmul;
  logic [egop_pkg::KNOT_W-1:0]     frac;
  logic signed [6:0]               ex;
  logic signed [egop_pkg::LG_W-1:0] lg5_r, lg5_nxt;
  logic [egop_pkg::SUM_W-1:0]      s5_r;
  logic                            z5_r;

  // exponent product
  logic signed [47:0]              zprod;
  logic signed [egop_pkg::Z_W-1:0] z6_r;
  logic [egop_pkg::SUM_W-1:0]      s6_r;
  logic                            z6z_r;

  // exp interpolation
  logic [EPOS_W-1:0]               epos;
  logic [egop_pkg::EXP_BITS-1:0]   eseg;
  logic [egop_pkg::EXP_BITS:0]     eseg1;
  logic [egop_pkg::KNOT_W-1:0]     ek0, ek1, ediff;
  logic [33:0]                     emul;
  logic [egop_pkg::KNOT_W-1:0]     e7_r, e7_nxt;
  logic signed [15:0]              n7_r;
  logic [egop_pkg::SUM_W-1:0]      s7_r;
  logic                            z7_r;

  // shift and select
  logic [15:0]                m;
  logic [49:0]                lsh;
  logic [39:0]                rsh;
  logic [egop_pkg::Y_W-1:0]   y8_r, y8_nxt;

  // gain and rescale
  logic [egop_pkg::Q_W-1:0]   q9_r;
  logic [66:0]                scl;
  logic [egop_pkg::CODE_W-1:0] code_nxt;

  always_comb begin
    sum = $signed({4'd0, v2_r}) + $signed({term[egop_pkg::TERM_W-1], term});
    s3_nxt = sum[egop_pkg::SUM_W] ? '0 : sum[egop_pkg::SUM_W-1:0];
  end

  always_comb begin
    e_lz = '0;
    for (int i = 0; i < egop_pkg::SUM_W; i++) begin
      if (s3_r[i]) e_lz = 5'(i);
    end
    nrm = s3_r << (5'(egop_pkg::SUM_W - 1) - e_lz);
  end

  always_comb begin
    lpos  = LPOS_W'(t4_r) * LPOS_W'(egop_pkg::LOG_SEG);
    lseg  = lpos[16 +: egop_pkg::LOG_BITS];
    lseg1 = {1'b0, lseg} + 1'b1;
    lk0   = egop_pkg::LOG_TAB[lseg];
    lk1   = egop_pkg::LOG_TAB[lseg1];
    ldiff = lk1 - lk0;
    lmul  = 34'(ldiff) * 34'(lpos[15:0]) + 34'd32768;
    frac  = lk0 + egop_pkg::KNOT_W'(lmul[33:16]);
    ex    = $signed({2'b00, e4_r}) - 7'sd16;
    lg5_nxt = $signed({ex[5:0], 16'h0000}) + $signed({4'd0, frac});
  end

  assign zprod = $signed({23'd0, cfg.inv_gamma}) * 48'(lg5_r) + 48'sd32768;

  always_comb begin
    epos  = EPOS_W'(z6_r[15:0]) * EPOS_W'(egop_pkg::EXP_SEG);
    eseg  = epos[16 +: egop_pkg::EXP_BITS];
    eseg1 = {1'b0, eseg} + 1'b1;
    ek0   = egop_pkg::EXP_TAB[eseg];
    ek1   = egop_pkg::EXP_TAB[eseg1];
    ediff = ek1 - ek0;
    emul  = 34'(ediff) * 34'(epos[15:0]) + 34'd32768;
    e7_nxt = ek0 + egop_pkg::KNOT_W'(emul[33:16]);
  end

  always_comb begin
    m   = 16'(-n7_r);
    lsh = 50'(e7_r) << n7_r[4:0];
    rsh = (40'(e7_r) + (40'd1 << (m[5:0] - 6'd1))) >> m[5:0];
    if (!cfg.gamma_en) begin
      y8_nxt = egop_pkg::Y_W'(s7_r);
    end else if (z7_r) begin
      y8_nxt = '0;
    end else if (!n7_r[15]) begin
      if (n7_r > 16'sd16 || lsh > 50'h1_0000_0000) y8_nxt = 33'h1_0000_0000;
      else                                           y8_nxt = lsh[32:0];
    end else if (m >= 16'd40) begin
      y8_nxt = '0;
    end else begin
      y8_nxt = 33'(rsh);
    end
  end

  always_comb begin
    scl = (67'(q9_r) << 8) - 67'(q9_r) + (67'd1 << 31);
    if (q9_r >= (58'd1 << 32)) begin
      code_nxt = cfg.depth16 ? 16'd32768 : 16'd255;
    end else if (cfg.depth16) begin
      code_nxt = 16'((q9_r + 58'd65536) >> 17);
    end else begin
      code_nxt = 16'(scl >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) v2_r <= norm;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) begin
      e4_r <= e_lz;
      t4_r <= nrm[egop_pkg::SUM_W-2 -: 16];
      s4_r <= s3_r;
      z4_r <= (s3_r == '0);
    end
    if (en[4]) begin
      lg5_r <= lg5_nxt;
      s5_r  <= s4_r;
      z5_r  <= z4_r;
    end
    if (en[5]) begin
      z6_r  <= zprod[47:16];
      s6_r  <= s5_r;
      z6z_r <= z5_r;
    end
    if (en[6]) begin
      e7_r <= e7_nxt;
      n7_r <= z6_r[31:16];
      s7_r <= s6_r;
      z7_r <= z6z_r;
    end
    if (en[7]) y8_r <= y8_nxt;
    if (en[8]) q9_r <= 58'(y8_r) * 58'(cfg.gain);
    if (en[9]) code_r <= code_nxt;
  end

endmodule
`default_nettype wire

### design/exposure_gamma_offset_pixel_top.sv
// Top level: config registers, pipeline control, alpha offset term and three color lanes
//
//  channel | ports                                  | direction
//  input   | in_valid in_stall in_*_in             | into block
//  result  | out_valid out_stall out_*_out         | out of block
//  config  | cfg_we cfg_index cfg_wdata            | into block
//
// One pixel per clock sustained while out_stall is low; the pipeline has ten stages.
// out_valid is the valid bit of the last stage, whose registers drive the result ports.
// Each stage holds one pixel and advances when the next stage is empty or advancing,
// so bubbles collapse and input transfers continue while a result waits, until all
// ten stages hold pixels.
// Synchronous active-low reset clears valids and loads register defaults.
`default_nettype none
module exposure_gamma_offset_pixel_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_red_in,
  input  wire logic [15:0] in_green_in,
  input  wire logic [15:0] in_blue_in,
  input  wire logic [15:0] in_alpha_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_red_out,
  output logic [15:0]      out_green_out,
  output logic [15:0]      out_blue_out,
  output logic [15:0]      out_alpha_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata
);

  localparam int N = egop_pkg::NSTG;

  logic                depth_r;
  logic signed [17:0]  offset_r;
  logic                gamma_r;
  logic [24:0]         invg_r;
  logic [24:0]         gain_r;

  logic [N-1:0] vld_r;
  logic [N:0]   rdy;
  logic [N-1:0] en;

  egop_pkg::lane_cfg_t lcfg;

  logic [egop_pkg::NORM_W-1:0] r_n, g_n, b_n, a_n;
  logic [15:0]                 alpha_r [N];
  logic signed [43:0]          tprod;
  logic signed [egop_pkg::TERM_W-1:0] term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= 1'b0;
      offset_r <= '0;
      gamma_r  <= 1'b0;
      invg_r   <= 25'd65536;
      gain_r   <= 25'd65536;
    end else if (cfg_we) begin
      unique case (egop_pkg::reg_idx_t'(cfg_index))
        egop_pkg::REG_DEPTH:  depth_r  <= cfg_wdata[0];
        egop_pkg::REG_OFFSET: offset_r <= $signed(cfg_wdata[17:0]);
        egop_pkg::REG_GAMMA:  gamma_r  <= cfg_wdata[0];
        egop_pkg::REG_INVG:   invg_r   <= cfg_wdata;
        egop_pkg::REG_GAIN:   gain_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its content moves on
  always_comb begin
    rdy[N] = !out_stall;
    for (int k = N - 1; k >= 0; k--) rdy[k] = !vld_r[k] || rdy[k+1];
    en = rdy[N-1:0];
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign lcfg = '{depth16: depth_r, gamma_en: gamma_r, inv_gamma: invg_r, gain: gain_r};

  egop_norm u_norm_r (.clk, .en(en[0]), .depth16(depth_r), .code(in_red_in),   .norm_r(r_n));
  egop_norm u_norm_g (.clk, .en(en[0]), .depth16(depth_r), .code(in_green_in), .norm_r(g_n));
  egop_norm u_norm_b (.clk, .en(en[0]), .depth16(depth_r), .code(in_blue_in),  .norm_r(b_n));
  egop_norm u_norm_a (.clk, .en(en[0]), .depth16(depth_r), .code(in_alpha_in), .norm_r(a_n));

  // offset times normalized alpha, rounded and floored to Q16
  assign tprod = 44'(offset_r) * $signed({19'd0, a_n}) + 44'sd32768;

  always_ff @(posedge clk) begin
    if (en[1]) term_r <= tprod[43:16];
    if (en[0]) alpha_r[0] <= in_alpha_in;
    for (int k = 1; k < N; k++) begin
      if (en[k]) alpha_r[k] <= alpha_r[k-1];
    end
  end

  egop_lane u_lane_r (.clk, .en, .cfg(lcfg), .norm(r_n), .term(term_r), .code_r(out_red_out));
  egop_lane u_lane_g (.clk, .en, .cfg(lcfg), .norm(g_n), .term(term_r), .code_r(out_green_out));
  egop_lane u_lane_b (.clk, .en, .cfg(lcfg), .norm(b_n), .term(term_r), .code_r(out_blue_out));

  assign out_valid     = vld_r[N-1];
  assign out_alpha_out = alpha_r[N-1];

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red_out <= 16'd32768 && out_green_out <= 16'd32768
                   && out_blue_out <= 16'd32768))
    else $error("color code above channel maximum");

endmodule
`default_nettype wire
